[rtl/core/ipv4_header_builder_assert.svh]
// ----------------------------------------------------------------------------
// ipv4_header_builder assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_BUILDER_ASSERT_SVH
`define IPV4_HEADER_BUILDER_ASSERT_SVH

// property must hold in the same cycle
`define IHB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property must hold in the next cycle
`define IHB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ihb_pkg.sv]
// ----------------------------------------------------------------------------
// ihb_pkg
// shared types and constants of the ipv4 header builder
// ----------------------------------------------------------------------------
package ihb_pkg;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned CfgIndexW  = 2;
	localparam int unsigned HdrWords   = 10;
	localparam int unsigned WordIdxW   = 4;

	localparam logic [CfgIndexW-1:0] CFG_LOCAL_IP = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_MAX_LEN  = 2'd1;

	localparam logic [15:0] MaxLenReset = 16'd1500;
	localparam logic [15:0] IdentReset  = 16'd1;
	localparam logic [16:0] HdrBytes    = 17'd20;
	localparam logic [15:0] VerIhlTos   = 16'h4500;
	localparam logic [15:0] FlagsFrag   = 16'h4000;
	localparam logic [7:0]  TtlValue    = 8'd64;

	// header word positions
	localparam logic [WordIdxW-1:0] W_VER    = 4'd0;
	localparam logic [WordIdxW-1:0] W_LEN    = 4'd1;
	localparam logic [WordIdxW-1:0] W_IDENT  = 4'd2;
	localparam logic [WordIdxW-1:0] W_FLAGS  = 4'd3;
	localparam logic [WordIdxW-1:0] W_TTL    = 4'd4;
	localparam logic [WordIdxW-1:0] W_CSUM   = 4'd5;
	localparam logic [WordIdxW-1:0] W_SRC_HI = 4'd6;
	localparam logic [WordIdxW-1:0] W_SRC_LO = 4'd7;
	localparam logic [WordIdxW-1:0] W_DST_HI = 4'd8;
	localparam logic [WordIdxW-1:0] W_DST_LO = 4'd9;

	typedef struct packed {
		logic        too_long;
		logic [15:0] pkt_len;
		logic [15:0] ident;
		logic [7:0]  proto;
		logic [15:0] csum;
		logic [31:0] dest;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[rtl/core/ihb_front.sv]
// ----------------------------------------------------------------------------
// ihb_front
// takes requests, checks length, assigns identification, forms checksum
// ----------------------------------------------------------------------------
module ihb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          dest_addr,
	input  logic [7:0]           proto_num,
	input  logic [15:0]          payload_bytes,
	input  logic [31:0]          local_ip,
	input  logic [15:0]          max_packet_len,
	input  ihb_pkg::q_stat_t     q_stat,
	output logic                 push,
	output ihb_pkg::desc_t       push_desc
);

	logic        valid_s1;
	logic [31:0] dest_s1;
	logic [7:0]  proto_s1;
	logic [16:0] total_s1;
	logic [15:0] ident_q;
	logic        in_xfer;
	logic        err;
	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign in_stall = valid_s1 && q_stat.full;
	assign in_xfer  = in_valid && !in_stall;
	assign push     = valid_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dest_s1  <= dest_addr;
			proto_s1 <= proto_num;
			total_s1 <= ihb_pkg::HdrBytes + {1'b0, payload_bytes};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= ihb_pkg::IdentReset;
		end else if (push && !err) begin
			ident_q <= ident_q + 16'd1;
		end
	end

	assign err = total_s1 > {1'b0, max_packet_len};

	always_comb begin
		sum = 20'(ihb_pkg::VerIhlTos) + 20'(total_s1[15:0]) + 20'(ident_q)
			+ 20'(ihb_pkg::FlagsFrag) + 20'({ihb_pkg::TtlValue, proto_s1})
			+ 20'(local_ip[31:16]) + 20'(local_ip[15:0])
			+ 20'(dest_s1[31:16]) + 20'(dest_s1[15:0]);
		fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
		fold2 = fold1[15:0] + 16'(fold1[16]);
	end

	always_comb begin
		push_desc.too_long = err;
		push_desc.pkt_len  = total_s1[15:0];
		push_desc.ident    = ident_q;
		push_desc.proto    = proto_s1;
		push_desc.csum     = ~fold2;
		push_desc.dest     = dest_s1;
	end

endmodule

[rtl/core/ihb_queue.sv]
// ----------------------------------------------------------------------------
// ihb_queue
// small descriptor queue between front and back
// ----------------------------------------------------------------------------
module ihb_queue #(
	parameter int unsigned DEPTH = ihb_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ihb_pkg::desc_t   push_desc,
	input  logic             pop,
	output ihb_pkg::desc_t   head,
	output ihb_pkg::q_stat_t q_stat
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	ihb_pkg::desc_t  mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = count_q == FullCnt;
	assign q_stat.empty = count_q == '0;

endmodule

[rtl/core/ihb_back.sv]
// ----------------------------------------------------------------------------
// ihb_back
// walks the header words of the queue head into the output register
// ----------------------------------------------------------------------------
module ihb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ihb_pkg::desc_t   head,
	input  ihb_pkg::q_stat_t q_stat,
	input  logic [31:0]      local_ip,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [15:0]      header_word,
	output logic             too_long,
	output logic             last_word
);

	localparam logic [ihb_pkg::WordIdxW-1:0] LastIdx =
		ihb_pkg::WordIdxW'(ihb_pkg::HdrWords - 1);

	logic [ihb_pkg::WordIdxW-1:0] cnt_q;
	logic                         out_valid_q;
	logic [15:0]                  word_q;
	logic                         too_long_q;
	logic                         last_q;
	logic                         load;
	logic                         is_last;
	logic [15:0]                  word;

	assign load    = !q_stat.empty && (!out_valid_q || !out_stall);
	assign is_last = head.too_long || (cnt_q == LastIdx);
	assign pop     = load && is_last;

	always_comb begin
		unique case (cnt_q)
			ihb_pkg::W_VER:    word = ihb_pkg::VerIhlTos;
			ihb_pkg::W_LEN:    word = head.pkt_len;
			ihb_pkg::W_IDENT:  word = head.ident;
			ihb_pkg::W_FLAGS:  word = ihb_pkg::FlagsFrag;
			ihb_pkg::W_TTL:    word = {ihb_pkg::TtlValue, head.proto};
			ihb_pkg::W_CSUM:   word = head.csum;
			ihb_pkg::W_SRC_HI: word = local_ip[31:16];
			ihb_pkg::W_SRC_LO: word = local_ip[15:0];
			ihb_pkg::W_DST_HI: word = head.dest[31:16];
			ihb_pkg::W_DST_LO: word = head.dest[15:0];
			default:           word = '0;
		endcase
		if (head.too_long) begin
			word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= is_last ? '0 : cnt_q + ihb_pkg::WordIdxW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q     <= word;
			too_long_q <= head.too_long;
			last_q     <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign header_word = word_q;
	assign too_long    = too_long_q;
	assign last_word   = last_q;

endmodule

[rtl/core/ipv4_header_builder.sv]
// ----------------------------------------------------------------------------
// ipv4_header_builder
// builds the 20-byte ipv4 header with checksum as ten 16-bit words
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    dest_addr, proto_num, payload_bytes
//  out      out  out_valid/out_stall  header_word, too_long, last_word
//  cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  a header leaves as the ten header words, one word per cycle while
//  out_stall is low; a too-long request gives a single zero word
//  first word passes the front stage, the queue and the output register
//  front stage and queue keep taking requests while the output is stalled,
//  until both are full
//  reset: local_ip 0, max_packet_len 1500, identification 1
// ----------------------------------------------------------------------------
`include "ipv4_header_builder_assert.svh"

module ipv4_header_builder #(
	parameter int unsigned QUEUE_DEPTH = ihb_pkg::QueueDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   dest_addr,
	input  logic [7:0]                    proto_num,
	input  logic [15:0]                   payload_bytes,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   header_word,
	output logic                          too_long,
	output logic                          last_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ihb_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	logic [31:0]      local_ip_q;
	logic [15:0]      max_len_q;
	logic             push;
	logic             pop;
	ihb_pkg::desc_t   push_desc;
	ihb_pkg::desc_t   head;
	ihb_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
			max_len_q  <= ihb_pkg::MaxLenReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ihb_pkg::CFG_LOCAL_IP: local_ip_q <= cfg_data;
				ihb_pkg::CFG_MAX_LEN:  max_len_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ihb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.dest_addr      (dest_addr),
		.proto_num      (proto_num),
		.payload_bytes  (payload_bytes),
		.local_ip       (local_ip_q),
		.max_packet_len (max_len_q),
		.q_stat         (q_stat),
		.push           (push),
		.push_desc      (push_desc)
	);

	ihb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	ihb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.local_ip    (local_ip_q),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.header_word (header_word),
		.too_long    (too_long),
		.last_word   (last_word)
	);

	`IHB_ASSERT_NOW(a_err_shape, out_valid && too_long, last_word && (header_word == 16'd0), "error result malformed")
	`IHB_ASSERT_NOW(a_stall_full, in_stall, q_stat.full, "input stalled with room in queue")
	`IHB_ASSERT_NOW(a_queue_stat, q_stat.full, !q_stat.empty, "queue full and empty")
	`IHB_ASSERT_NEXT(a_push_room, push && q_stat.full, 1'b0, "push into full queue")

endmodule
